>>> rtl/core/f8cv_pkg.sv
// f8cv_pkg: shared types and constants for the FP8/FP32 converter.
// Depends on nothing.
package f8cv_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ByteW = 8;

  typedef enum logic {
    FMT_E4M3 = 1'b0,
    FMT_E5M2 = 1'b1
  } fmt_e;

  typedef enum logic {
    ACT_DECODE = 1'b0,
    ACT_ENCODE = 1'b1
  } act_e;

  localparam logic [WordW-1:0] Fp32Inf  = 32'h7F80_0000;
  localparam logic [WordW-1:0] Fp32QNan = 32'h7FC0_0000;
  localparam logic [6:0]       E5Inf    = 7'h7C;
  localparam logic [6:0]       E5Nan    = 7'h7D;
  localparam logic [6:0]       E4Sat    = 7'h7F;

  // stage 1 -> stage 2 classification of an encode request
  typedef struct packed {
    logic       sign;
    logic       zero;
    logic       infnan;
    logic       nan;
    logic       tiny;
    logic       big;
    logic       sub;
    logic [4:0] e;
    logic [2:0] m;
    logic       rnd;
  } enc_cls_t;

endpackage

>>> rtl/core/f8cv_stage1.sv
// f8cv_stage1: first pipeline stage, decodes bytes and classifies words to encode.
// Depends on f8cv_pkg.
module f8cv_stage1 (
  input  logic                    fmt_i,
  input  logic [7:0]              byte_i,
  input  logic [31:0]             word_i,
  output logic [31:0]             dec_word_o,
  output f8cv_pkg::enc_cls_t      cls_o
);
  import f8cv_pkg::*;

  logic       s;
  logic [7:0] ef;
  logic [22:0] fm;
  logic [8:0] ue9;
  logic       stk4, stk5;
  logic [1:0] sh;
  logic [23:0] full;
  logic [23:0] shd;

  always_comb begin
    // decode
    dec_word_o = '0;
    if (fmt_i == FMT_E4M3) begin
      if (byte_i[6:0] == 7'd0) dec_word_o = {byte_i[7], 31'd0};
      else dec_word_o = {byte_i[7], 8'({4'd0, byte_i[6:3]} + 8'd119), byte_i[2:0], 20'd0};
    end else begin
      unique case (byte_i[6:2])
        5'd0: begin
          unique case (byte_i[1:0])
            2'd1: dec_word_o = {byte_i[7], 8'd111, 23'd0};
            2'd2: dec_word_o = {byte_i[7], 8'd112, 23'd0};
            2'd3: dec_word_o = {byte_i[7], 8'd112, 23'h40_0000};
            default: dec_word_o = {byte_i[7], 31'd0};
          endcase
        end
        5'd31: dec_word_o = {byte_i[7], (byte_i[1:0] == 2'd0) ? Fp32Inf[30:0] : Fp32QNan[30:0]};
        default: dec_word_o = {byte_i[7], 8'({3'd0, byte_i[6:2]} + 8'd112), byte_i[1:0], 21'd0};
      endcase
    end

    // encode classification; ue9 = exp - 127 as 9-bit signed
    s    = word_i[31];
    ef   = word_i[30:23];
    fm   = word_i[22:0];
    ue9  = {1'b0, ef} - 9'd127;
    stk4 = |fm[18:0];
    stk5 = |fm[19:0];
    sh   = 2'(9'd0 - ue9 - 9'd14);
    full = {1'b1, fm};
    shd  = full >> (5'd21 + {3'd0, sh});
    cls_o = '0;
    cls_o.sign   = s;
    cls_o.zero   = (word_i[30:0] == 31'd0);
    cls_o.infnan = (ef == 8'hFF);
    cls_o.nan    = (fm != 23'd0);
    if (fmt_i == FMT_E4M3) begin
      cls_o.tiny = (ef < 8'd119);
      cls_o.big  = (ef > 8'd134);
      cls_o.e    = 5'(ef - 8'd119);
      cls_o.m    = fm[22:20];
      cls_o.rnd  = fm[19] & (stk4 | fm[20]);
    end else begin
      cls_o.tiny = (ef < 8'd110);
      cls_o.sub  = (ef >= 8'd110) && (ef < 8'd113);
      cls_o.big  = (ef > 8'd142);
      cls_o.e    = 5'(ef - 8'd112);
      cls_o.m    = cls_o.sub ? {1'b0, shd[1:0]} : {1'b0, fm[22:21]};
      cls_o.rnd  = ~cls_o.sub & fm[20] & (stk5 | fm[21]);
    end
  end

endmodule

>>> rtl/core/f8cv_stage2.sv
// f8cv_stage2: rounding and special-case selection for encode requests.
// Depends on f8cv_pkg.
module f8cv_stage2 (
  input  logic               fmt_i,
  input  f8cv_pkg::enc_cls_t cls_i,
  output logic [7:0]         byte_o
);
  import f8cv_pkg::*;

  logic [3:0] mr;
  logic [5:0] er;

  always_comb begin
    byte_o = '0;
    if (fmt_i == FMT_E4M3) begin
      mr = {1'b0, cls_i.m} + {3'd0, cls_i.rnd};
      er = {1'b0, cls_i.e} + {5'd0, mr[3]};
      priority if (cls_i.zero || (cls_i.tiny && !cls_i.infnan)) byte_o = {cls_i.sign, 7'd0};
      else if (cls_i.infnan || cls_i.big || er > 6'd15) byte_o = {cls_i.sign, E4Sat};
      else byte_o = {cls_i.sign, er[3:0], mr[2:0]};
    end else begin
      mr = {2'd0, cls_i.m[1:0]} + {3'd0, cls_i.rnd};
      er = {1'b0, cls_i.e} + {5'd0, mr[2]};
      priority if (cls_i.zero) byte_o = {cls_i.sign, 7'd0};
      else if (cls_i.infnan) byte_o = {cls_i.sign, cls_i.nan ? E5Nan : E5Inf};
      else if (cls_i.tiny) byte_o = {cls_i.sign, 7'd0};
      else if (cls_i.sub) byte_o = {cls_i.sign, 5'd0, cls_i.m[1:0]};
      else if (cls_i.big || er > 6'd30) byte_o = {cls_i.sign, E5Inf};
      else byte_o = {cls_i.sign, er[4:0], mr[1:0]};
    end
  end

endmodule

>>> rtl/core/fp8_fp32_format_converter.sv
// fp8_fp32_format_converter: top level, three-stage pipeline.
// Depends on f8cv_pkg, f8cv_stage1, f8cv_stage2.
//
//  channel | valid / ready           | payload
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_data_i (format_select)
//  in      | in_valid_i/in_ready_o   | action_i, byte_in_i, word_in_i
//  out     | out_valid_o/out_ready_i | word_out_o, byte_out_o
//
// One request per cycle when the output is not stalled; the stages classify and
// decode, pass through, and round into the output register.
// Every stage holds while the stage after it is full and stalled.
// Reset clears the stage valid bits and sets format_select to E4M3.
module fp8_fp32_format_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  byte_in_i,
  input  logic [31:0] word_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] word_out_o,
  output logic [7:0]  byte_out_o
);
  import f8cv_pkg::*;

  logic fmt_q;
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic a1_q, a2_q;
  logic [31:0] w1_q, w2_q, w3_q, dec_w;
  logic [7:0]  b3_q, enc_b;
  enc_cls_t c1_q, c2_q, cls;

  assign cfg_ready_o = 1'b1;

  assign en3 = ~v3_q | out_ready_i;
  assign en2 = ~v2_q | en3;
  assign en1 = ~v1_q | en2;
  assign in_ready_o = en1;

  f8cv_stage1 u_s1 (.fmt_i(fmt_q), .byte_i(byte_in_i), .word_i(word_in_i),
                    .dec_word_o(dec_w), .cls_o(cls));
  f8cv_stage2 u_s2 (.fmt_i(fmt_q), .cls_i(c2_q), .byte_o(enc_b));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_E4M3;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) fmt_q <= cfg_data_i;
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      a1_q <= action_i;
      w1_q <= (action_i == ACT_DECODE) ? dec_w : '0;
      c1_q <= cls;
    end
    if (en2 && v1_q) begin
      a2_q <= a1_q;
      w2_q <= w1_q;
      c2_q <= c1_q;
    end
    if (en3 && v2_q) begin
      w3_q <= w2_q;
      b3_q <= (a2_q == ACT_ENCODE) ? enc_b : '0;
    end
  end

  assign out_valid_o = v3_q;
  assign word_out_o  = w3_q;
  assign byte_out_o  = b3_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(word_out_o) && $stable(byte_out_o))
    else $error("output changed under stall");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (word_out_o == 32'd0) || (byte_out_o == 8'd0))
    else $error("both result fields nonzero");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !en3 |=> v2_q)
    else $error("stage two lost a request");

endmodule
